// File: sv/fpvc_pkg.sv
// Package: shared types, constants and coefficient table of the flow/pressure/volume conditioner.
package fpvc_pkg;

  localparam int ADC_BITS_DEF        = 12;
  localparam int SLICE_MS_DEF        = 10;
  localparam int FLOW_OFFSET_MIN_DEF = -4000;
  localparam int FLOW_OFFSET_MAX_DEF = 4000;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam int CODE_W  = 12;
  localparam int X_W     = 13;
  localparam int MULA_W  = 33;
  localparam int PROD_W  = MULA_W + X_W;
  localparam int ACC_W   = 30;
  localparam int Y_W     = ACC_W - 2;
  localparam int RCP_W   = 29;
  localparam int DPROD_W = Y_W + RCP_W;
  localparam int Q_W     = DPROD_W - 32;

  localparam int FLOW_W = 17;
  localparam int PRES_W = 16;
  localparam int VOL_W  = 24;

  localparam logic signed [X_W-1:0] BREAK_LO = -13'sd2900;
  localparam logic signed [X_W-1:0] BREAK_HI = 13'sd3200;

  localparam logic [ACC_W-1:0] ACC_TOP   = 30'd1006632900;
  localparam logic [RCP_W-1:0] RECIP_15  = 29'd286331153;
  localparam logic signed [63:0] ROUND_HALF = 64'sd549755813888;

  localparam logic [1:0] ACT_INTEGRATE = 2'd1;
  localparam logic [1:0] ACT_CLEAR     = 2'd2;

  localparam logic signed [63:0] CUBIC_ROM [4][4] = '{
    '{64'sd0, 64'sd50286912, 64'sd3993020908116, -64'sd4137682157646643},
    '{-64'sd223615, -64'sd750800723, 64'sd4976674620728, 64'sd0},
    '{-64'sd85716, 64'sd173205064, 64'sd5161634642674, 64'sd0},
    '{64'sd0, -64'sd32138531, 64'sd3808668872119, 64'sd3631027199567462}
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLOW_ZERO     = 3'd0,
    REG_FLOW_DEADBAND = 3'd1,
    REG_FLOW_MAX      = 3'd2,
    REG_FLOW_MIN      = 3'd3,
    REG_PRES_ZERO     = 3'd4,
    REG_PRES_DEADBAND = 3'd5,
    REG_PRES_CLAMP    = 3'd6,
    REG_PRES_GAIN     = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [11:0]        flow_zero_code;
    logic [15:0]        flow_deadband;
    logic signed [16:0] flow_max;
    logic signed [16:0] flow_min;
    logic [11:0]        pressure_zero_code;
    logic [11:0]        pressure_deadband;
    logic [11:0]        pressure_clamp_code;
    logic [15:0]        pressure_gain;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_ADD,
    ST_MUL_P,
    ST_FIN,
    ST_VOL,
    ST_DIV,
    ST_EMIT
  } state_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD,
    OP_MUL_P,
    OP_FIN,
    OP_VOL,
    OP_DIV,
    OP_EMIT
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] step;
  } dp_cmd_t;

endpackage

// File: sv/fpvc_regs.sv
// Configuration register bank of the conditioner.
module fpvc_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fpvc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fpvc_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output fpvc_pkg::cfg_t                      cfg
);

  fpvc_pkg::cfg_t cfg_r;
  fpvc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (fpvc_pkg::cfg_reg_t'(cfg_index))
        fpvc_pkg::REG_FLOW_ZERO:     cfg_nxt.flow_zero_code      = cfg_wdata[11:0];
        fpvc_pkg::REG_FLOW_DEADBAND: cfg_nxt.flow_deadband       = cfg_wdata[15:0];
        fpvc_pkg::REG_FLOW_MAX:      cfg_nxt.flow_max            = $signed(cfg_wdata[16:0]);
        fpvc_pkg::REG_FLOW_MIN:      cfg_nxt.flow_min            = $signed(cfg_wdata[16:0]);
        fpvc_pkg::REG_PRES_ZERO:     cfg_nxt.pressure_zero_code  = cfg_wdata[11:0];
        fpvc_pkg::REG_PRES_DEADBAND: cfg_nxt.pressure_deadband   = cfg_wdata[11:0];
        fpvc_pkg::REG_PRES_CLAMP:    cfg_nxt.pressure_clamp_code = cfg_wdata[11:0];
        fpvc_pkg::REG_PRES_GAIN:     cfg_nxt.pressure_gain       = cfg_wdata[15:0];
        default:                     cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flow_zero_code      <= 12'd2048;
      cfg_r.flow_deadband       <= 16'd0;
      cfg_r.flow_max            <= 17'sd65535;
      cfg_r.flow_min            <= -17'sd65536;
      cfg_r.pressure_zero_code  <= 12'd0;
      cfg_r.pressure_deadband   <= 12'd0;
      cfg_r.pressure_clamp_code <= 12'd4095;
      cfg_r.pressure_gain       <= 16'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/fpvc_ctrl.sv
// Controller: sequences the datapath and owns the input and output handshakes.
module fpvc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fpvc_pkg::dp_cmd_t cmd
);

  fpvc_pkg::state_t state_r;
  fpvc_pkg::state_t state_nxt;
  logic [1:0]       step_r;
  logic [1:0]       step_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fpvc_pkg::ST_IDLE;
      step_r      <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    in_ready      = 1'b0;
    cmd.op        = fpvc_pkg::OP_IDLE;
    cmd.step      = step_r;
    case (state_r)
      fpvc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = fpvc_pkg::OP_LOAD;
          step_nxt  = 2'd0;
          state_nxt = fpvc_pkg::ST_MUL_LO;
        end
      end
      fpvc_pkg::ST_MUL_LO: begin
        cmd.op    = fpvc_pkg::OP_MUL_LO;
        state_nxt = fpvc_pkg::ST_MUL_HI;
      end
      fpvc_pkg::ST_MUL_HI: begin
        cmd.op    = fpvc_pkg::OP_MUL_HI;
        state_nxt = fpvc_pkg::ST_ADD;
      end
      fpvc_pkg::ST_ADD: begin
        cmd.op = fpvc_pkg::OP_ADD;
        if (step_r == 2'd2) begin
          state_nxt = fpvc_pkg::ST_MUL_P;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = fpvc_pkg::ST_MUL_LO;
        end
      end
      fpvc_pkg::ST_MUL_P: begin
        cmd.op    = fpvc_pkg::OP_MUL_P;
        state_nxt = fpvc_pkg::ST_FIN;
      end
      fpvc_pkg::ST_FIN: begin
        cmd.op    = fpvc_pkg::OP_FIN;
        state_nxt = fpvc_pkg::ST_VOL;
      end
      fpvc_pkg::ST_VOL: begin
        cmd.op    = fpvc_pkg::OP_VOL;
        state_nxt = fpvc_pkg::ST_DIV;
      end
      fpvc_pkg::ST_DIV: begin
        cmd.op    = fpvc_pkg::OP_DIV;
        state_nxt = fpvc_pkg::ST_EMIT;
      end
      fpvc_pkg::ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = fpvc_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = fpvc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fpvc_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == fpvc_pkg::ST_MUL_LO && step_r == 2'd0)
    else $error("accepted word did not start the cubic");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.op == fpvc_pkg::OP_EMIT |-> !out_valid_r || out_ready)
    else $error("result overwrote a pending output word");

  a_three_steps: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == fpvc_pkg::ST_ADD && step_r == 2'd2 |=> state_r == fpvc_pkg::ST_MUL_P)
    else $error("cubic did not end after the third step");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != fpvc_pkg::ST_IDLE |-> step_r != 2'd3)
    else $error("step counter out of range");
`endif

endmodule

// File: sv/fpvc_datapath.sv
// Datapath: offset/clamp front end, shared multiplier, cubic evaluation, volume and output registers.
module fpvc_datapath #(
  parameter int ADC_BITS        = fpvc_pkg::ADC_BITS_DEF,
  parameter int SLICE_MS        = fpvc_pkg::SLICE_MS_DEF,
  parameter int FLOW_OFFSET_MIN = fpvc_pkg::FLOW_OFFSET_MIN_DEF,
  parameter int FLOW_OFFSET_MAX = fpvc_pkg::FLOW_OFFSET_MAX_DEF
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  fpvc_pkg::dp_cmd_t                         cmd,
  input  fpvc_pkg::cfg_t                            cfg,
  input  logic [ADC_BITS-1:0]                       in_flow_code,
  input  logic [ADC_BITS-1:0]                       in_pressure_code,
  input  logic [1:0]                                in_action,
  output logic signed [fpvc_pkg::FLOW_W-1:0]        out_flow,
  output logic signed [fpvc_pkg::PRES_W-1:0]        out_pressure,
  output logic [fpvc_pkg::VOL_W-1:0]                out_volume
);

  localparam int XW = ((ADC_BITS > fpvc_pkg::CODE_W) ? ADC_BITS : fpvc_pkg::CODE_W) + 1;
  localparam logic signed [XW-1:0] OFS_MIN = XW'(FLOW_OFFSET_MIN);
  localparam logic signed [XW-1:0] OFS_MAX = XW'(FLOW_OFFSET_MAX);
  localparam logic signed [24:0]   SLICE_K = 25'(SLICE_MS);
  localparam int PW = fpvc_pkg::PROD_W;
  localparam int XB = fpvc_pkg::X_W;

  // front end
  logic [XW-2:0]          fcode_u;
  logic [XW-2:0]          fzero_u;
  logic [XW-2:0]          pcode_u;
  logic [XW-2:0]          pzero_u;
  logic signed [XW-1:0]   x_raw;
  logic signed [XW-1:0]   x_cl;
  logic signed [XB-1:0]   x_in;
  logic [1:0]             seg_in;
  logic signed [XW-1:0]   p_raw;
  logic signed [XW-1:0]   p_db;
  logic signed [XW-1:0]   p_cl;
  logic signed [XW-1:0]   p_cut;

  always_comb begin
    fcode_u = (XW-1)'(in_flow_code);
    fzero_u = (XW-1)'(cfg.flow_zero_code);
    pcode_u = (XW-1)'(in_pressure_code);
    pzero_u = (XW-1)'(cfg.pressure_zero_code);
    x_raw   = $signed({1'b0, fcode_u}) - $signed({1'b0, fzero_u});
    x_cl    = x_raw;
    if (x_cl < OFS_MIN) x_cl = OFS_MIN;
    if (x_cl > OFS_MAX) x_cl = OFS_MAX;
    x_in = XB'(x_cl);
    if (x_in < fpvc_pkg::BREAK_LO) begin
      seg_in = 2'd0;
    end else if (x_in < $signed(XB'(0))) begin
      seg_in = 2'd1;
    end else if (x_in < fpvc_pkg::BREAK_HI) begin
      seg_in = 2'd2;
    end else begin
      seg_in = 2'd3;
    end
    p_raw = $signed({1'b0, pcode_u}) - $signed({1'b0, pzero_u});
    p_db  = $signed({1'b0, (XW-1)'(cfg.pressure_deadband)});
    p_cl  = $signed({1'b0, (XW-1)'(cfg.pressure_clamp_code)});
    p_cut = p_raw;
    if (p_cut < p_db && p_cut > -p_db) p_cut = '0;
    if (p_cut > p_cl) p_cut = p_cl;
  end

  // working registers
  logic signed [XB-1:0]               x_r;
  logic signed [XB-1:0]               p_r;
  logic [1:0]                         seg_r;
  logic [1:0]                         act_r;
  logic signed [63:0]                 acc_r;
  logic signed [63:0]                 part_r;
  logic signed [PW-1:0]               prod_r;
  logic signed [fpvc_pkg::FLOW_W-1:0] flow_r;
  logic signed [fpvc_pkg::PRES_W-1:0] pres_r;
  logic [fpvc_pkg::ACC_W-1:0]         accum_r;
  logic [fpvc_pkg::ACC_W-1:0]         accum_nxt;
  logic [fpvc_pkg::Y_W-1:0]           y_r;
  logic [fpvc_pkg::Q_W-1:0]           q_r;
  logic signed [fpvc_pkg::FLOW_W-1:0] out_flow_r;
  logic signed [fpvc_pkg::PRES_W-1:0] out_pressure_r;
  logic [fpvc_pkg::VOL_W-1:0]         out_volume_r;

  // shared multiplier
  logic signed [fpvc_pkg::MULA_W-1:0] mul_a;
  logic signed [XB-1:0]               mul_b;
  logic signed [PW-1:0]               mul_p;

  always_comb begin
    mul_a = '0;
    mul_b = x_r;
    case (cmd.op)
      fpvc_pkg::OP_MUL_LO: mul_a = $signed({1'b0, acc_r[31:0]});
      fpvc_pkg::OP_MUL_HI: mul_a = $signed({acc_r[63], acc_r[63:32]});
      fpvc_pkg::OP_MUL_P: begin
        mul_a = $signed({17'd0, cfg.pressure_gain});
        mul_b = p_r;
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // flow finish
  logic signed [63:0] v_rnd;
  logic signed [24:0] f_w;
  logic signed [24:0] f_db;
  logic signed [24:0] f_hi;
  logic signed [24:0] f_lo;
  logic signed [63:0] coef;
  logic [1:0]         coef_idx;

  always_comb begin
    v_rnd = acc_r + fpvc_pkg::ROUND_HALF;
    f_w   = {v_rnd[63], v_rnd[63:40]};
    f_db  = $signed({9'd0, cfg.flow_deadband});
    f_hi  = {{8{cfg.flow_max[16]}}, cfg.flow_max};
    f_lo  = {{8{cfg.flow_min[16]}}, cfg.flow_min};
    if (f_w < f_db && f_w > -f_db) f_w = '0;
    if (f_w > f_hi) f_w = f_hi;
    if (f_w < f_lo) f_w = f_lo;
    coef_idx = 2'(cmd.step + 2'd1);
    coef     = fpvc_pkg::CUBIC_ROM[seg_r][coef_idx];
  end

  // pressure saturation
  logic signed [PW-9:0] pr_sh;
  logic signed [fpvc_pkg::PRES_W-1:0] pr_sat;

  always_comb begin
    pr_sh = prod_r[PW-1:8];
    if (pr_sh > $signed((PW-8)'(32767))) begin
      pr_sat = 16'sh7FFF;
    end else if (pr_sh < -$signed((PW-8)'(32768))) begin
      pr_sat = -16'sh8000;
    end else begin
      pr_sat = pr_sh[15:0];
    end
  end

  // volume update
  logic signed [24:0] flow_ext;
  logic signed [24:0] inc;
  logic signed [31:0] vsum;

  always_comb begin
    flow_ext  = {{8{flow_r[16]}}, flow_r};
    inc       = flow_ext * SLICE_K;
    vsum      = $signed({2'b00, accum_r}) + $signed({{7{inc[24]}}, inc});
    accum_nxt = accum_r;
    if (act_r == fpvc_pkg::ACT_INTEGRATE) begin
      if (vsum < 0) begin
        accum_nxt = '0;
      end else if (vsum > $signed({2'b00, fpvc_pkg::ACC_TOP})) begin
        accum_nxt = fpvc_pkg::ACC_TOP;
      end else begin
        accum_nxt = vsum[fpvc_pkg::ACC_W-1:0];
      end
    end else if (act_r == fpvc_pkg::ACT_CLEAR) begin
      accum_nxt = '0;
    end
  end

  // divide by 60: shift by 2, then reciprocal of 15 with one correction
  logic [fpvc_pkg::Y_W-1:0]     y_in;
  logic [fpvc_pkg::DPROD_W-1:0] dprod;
  logic [fpvc_pkg::Y_W:0]       q15;
  logic [fpvc_pkg::Y_W:0]       rem;
  logic [fpvc_pkg::Q_W-1:0]     q_fix;

  always_comb begin
    y_in  = accum_r[fpvc_pkg::ACC_W-1:2];
    dprod = fpvc_pkg::DPROD_W'(y_in) * fpvc_pkg::DPROD_W'(fpvc_pkg::RECIP_15);
    q15   = (fpvc_pkg::Y_W+1)'({q_r, 4'd0}) - (fpvc_pkg::Y_W+1)'(q_r);
    rem   = {1'b0, y_r} - q15;
    q_fix = (rem >= (fpvc_pkg::Y_W+1)'(15)) ? q_r + 1'b1 : q_r;
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      fpvc_pkg::OP_LOAD: begin
        x_r   <= x_in;
        p_r   <= XB'(p_cut);
        seg_r <= seg_in;
        act_r <= in_action;
        acc_r <= fpvc_pkg::CUBIC_ROM[seg_in][0];
      end
      fpvc_pkg::OP_MUL_LO: prod_r <= mul_p;
      fpvc_pkg::OP_MUL_HI: begin
        part_r <= {{(64-PW){prod_r[PW-1]}}, prod_r} + coef;
        prod_r <= mul_p;
      end
      fpvc_pkg::OP_ADD: acc_r <= part_r + $signed({prod_r[31:0], 32'd0});
      fpvc_pkg::OP_MUL_P: prod_r <= mul_p;
      fpvc_pkg::OP_FIN: begin
        flow_r <= f_w[fpvc_pkg::FLOW_W-1:0];
        pres_r <= pr_sat;
      end
      fpvc_pkg::OP_DIV: begin
        y_r <= y_in;
        q_r <= dprod[fpvc_pkg::DPROD_W-1:32];
      end
      fpvc_pkg::OP_EMIT: begin
        out_flow_r     <= flow_r;
        out_pressure_r <= pres_r;
        out_volume_r   <= q_fix[fpvc_pkg::VOL_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (cmd.op == fpvc_pkg::OP_VOL) begin
      accum_r <= accum_nxt;
    end
  end

  assign out_flow     = out_flow_r;
  assign out_pressure = out_pressure_r;
  assign out_volume   = out_volume_r;

endmodule

// File: sv/flow_pressure_volume_conditioner.sv
// Top level of the flow, pressure and volume sensor conditioner.
// Input channel (in_valid/in_ready): one word per sample period with a flow
// ADC code, a pressure ADC code and a volume action (hold, integrate, clear).
// Output channel (out_valid/out_ready): one word per input word with the
// calibrated flow, the saturated pressure and the integrated volume.
// Configuration port (cfg_wr_en/cfg_index/cfg_wdata): single-cycle writes of
// the zero codes, deadbands, clamps and pressure gain; write only when idle.
// The sequencer takes no new word until the last one has gone through the
// controller sequence around the shared 33x13 multiplier (three Horner
// steps of multiply low, multiply high and add, one pressure product, flow
// finish, volume update and divide by sixty).
// in_ready is high whenever the sequencer is idle, also while a finished word
// still waits in the output register; a stalled receiver holds the output word
// and blocks only the last step of the next word.
// Reset clears the sequencer, the output valid, the volume accumulator and
// loads the configuration registers with their defaults.
module flow_pressure_volume_conditioner #(
  parameter int ADC_BITS        = fpvc_pkg::ADC_BITS_DEF,
  parameter int SLICE_MS        = fpvc_pkg::SLICE_MS_DEF,
  parameter int FLOW_OFFSET_MIN = fpvc_pkg::FLOW_OFFSET_MIN_DEF,
  parameter int FLOW_OFFSET_MAX = fpvc_pkg::FLOW_OFFSET_MAX_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [fpvc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [fpvc_pkg::CFG_DATA_W-1:0]       cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [ADC_BITS-1:0]                   in_flow_code,
  input  logic [ADC_BITS-1:0]                   in_pressure_code,
  input  logic [1:0]                            in_action,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [fpvc_pkg::FLOW_W-1:0]    out_flow,
  output logic signed [fpvc_pkg::PRES_W-1:0]    out_pressure,
  output logic [fpvc_pkg::VOL_W-1:0]            out_volume
);

  fpvc_pkg::cfg_t    cfg;
  fpvc_pkg::dp_cmd_t cmd;

  fpvc_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  fpvc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  fpvc_datapath #(
    .ADC_BITS        (ADC_BITS),
    .SLICE_MS        (SLICE_MS),
    .FLOW_OFFSET_MIN (FLOW_OFFSET_MIN),
    .FLOW_OFFSET_MAX (FLOW_OFFSET_MAX)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg              (cfg),
    .in_flow_code     (in_flow_code),
    .in_pressure_code (in_pressure_code),
    .in_action        (in_action),
    .out_flow         (out_flow),
    .out_pressure     (out_pressure),
    .out_volume       (out_volume)
  );

endmodule
